/* rtl/marked_frame_deframer_defines.svh */
// assertion macros for the deframer rtl, used by mfd_parser
`ifndef MARKED_FRAME_DEFRAMER_DEFINES_SVH
`define MARKED_FRAME_DEFRAMER_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define MFD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mfd check failed");

// antecedent holds, consequent holds in the next cycle
`define MFD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mfd check failed");

`endif

/* rtl/mfd_pkg.sv */
package mfd_pkg;

  localparam int FRAME_BYTES = 6;
  localparam int DATA_W      = 48;
  localparam int CNT_W       = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int OUT_TDATA_W = 56;

  localparam logic [7:0] START_MARKER_RST = 8'h24;
  localparam logic [7:0] TYPE_M = 8'h4d;
  localparam logic [7:0] TYPE_N = 8'h4e;
  localparam logic [7:0] TYPE_T = 8'h54;
  localparam logic [7:0] TYPE_L = 8'h4c;

  typedef enum logic [2:0] {
    EV_COLLECT = 3'd0,
    EV_START   = 3'd1,
    EV_REJECT  = 3'd2,
    EV_STORED  = 3'd3,
    EV_DROPPED = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    SLOT_M = 2'd0,
    SLOT_N = 2'd1,
    SLOT_T = 2'd2,
    SLOT_L = 2'd3
  } slot_e;

  typedef struct packed {
    event_e              ev;
    logic [1:0]          slot;
    logic [DATA_W-1:0]   data;
  } res_t;

  typedef struct packed {
    logic  hit;
    slot_e slot;
  } type_t;

  function automatic type_t type_of(input logic [7:0] letter);
    type_t t;
    t.hit  = 1'b1;
    t.slot = SLOT_M;
    unique case (letter)
      TYPE_M:  t.slot = SLOT_M;
      TYPE_N:  t.slot = SLOT_N;
      TYPE_T:  t.slot = SLOT_T;
      TYPE_L:  t.slot = SLOT_L;
      default: t.hit  = 1'b0;
    endcase
    return t;
  endfunction

endpackage

/* rtl/marked_frame_deframer.sv */
// Byte-stream deframer. Each received byte is one input transfer and gives exactly one result
// transfer: while idle, the start marker opens a frame and any other byte is rejected; inside a
// frame the next six bytes are collected, and the last one closes the frame with a stored or
// dropped event. A frame is stored when its first and last bytes match and the first byte is
// one of the type letters M, N, T or L. One byte is taken every cycle while the input side
// is not stalled. The byte lands in the input register at its transfer edge and its result
// moves on into the result register once that register is free, which raises m_axis_tvalid.
// The frame state register is the only loop. A result waiting on m_axis_tready stalls the
// input side only once both registers are full. start_marker resets to '$'; the user must
// write it through cfg_we_i/cfg_wdata_i while the block is idle, which is not enforced.
module marked_frame_deframer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [7:0]                        cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] rx_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mfd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata    // [2:0] event_res, [4:3] slot,
                                                            // [52:5] frame_data, rest zero
);

  logic [7:0]     start_marker_q;
  logic           in_vld_q;
  logic [7:0]     in_byte_q;
  logic           out_vld_q;
  mfd_pkg::res_t  out_q;
  mfd_pkg::res_t  res;
  logic           out_free;
  logic           step;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= mfd_pkg::START_MARKER_RST;
    end else if (cfg_we_i) begin
      start_marker_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_vld_q <= step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (step) begin
      out_q <= res;
    end
  end

  mfd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .marker_i (start_marker_q),
    .res_o    (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_q.data, out_q.slot, out_q.ev};

endmodule

/* rtl/mfd_parser.sv */
`include "marked_frame_deframer_defines.svh"

module mfd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic [7:0]        marker_i,
  output mfd_pkg::res_t     res_o
);

  localparam logic [mfd_pkg::CNT_W-1:0] LastIdx = mfd_pkg::CNT_W'(mfd_pkg::FRAME_BYTES - 1);

  logic                         in_frame_q, in_frame_d;
  logic [mfd_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [7:0]                   first_q;
  logic [mfd_pkg::DATA_W-1:0]   shift_q, shift_d;
  logic [mfd_pkg::DATA_W-1:0]   slot_q [4];
  logic                         last_byte;
  mfd_pkg::type_t               ftype;
  mfd_pkg::res_t                res;

  assign last_byte = (cnt_q == LastIdx);
  assign ftype     = mfd_pkg::type_of(first_q);
  // frame bytes shift in from the bottom, older ones fall off the top
  assign shift_d   = {shift_q[mfd_pkg::DATA_W-9:0], byte_i};

  always_comb begin
    res        = '{ev: mfd_pkg::EV_COLLECT, slot: 2'd0, data: '0};
    in_frame_d = in_frame_q;
    cnt_d      = cnt_q;
    if (!in_frame_q) begin
      cnt_d = '0;
      if (byte_i == marker_i) begin
        res.ev     = mfd_pkg::EV_START;
        in_frame_d = 1'b1;
      end else begin
        res.ev = mfd_pkg::EV_REJECT;
      end
    end else if (last_byte) begin
      res.data   = shift_d;
      in_frame_d = 1'b0;
      cnt_d      = '0;
      if (ftype.hit && (first_q == byte_i)) begin
        res.ev   = mfd_pkg::EV_STORED;
        res.slot = ftype.slot;
      end else begin
        res.ev = mfd_pkg::EV_DROPPED;
      end
    end else begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      cnt_q      <= '0;
    end else if (step_i) begin
      in_frame_q <= in_frame_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      if (!in_frame_q) begin
        shift_q <= '0;
      end else begin
        shift_q <= shift_d;
        if (cnt_q == '0) begin
          first_q <= byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        slot_q[i] <= '0;
      end
    end else if (step_i && (res.ev == mfd_pkg::EV_STORED)) begin
      slot_q[res.slot] <= res.data;
    end
  end

  `MFD_ASSERT_IMP(a_idle_cnt_zero, !in_frame_q, cnt_q == '0)
  `MFD_ASSERT_NXT(a_store_written, step_i && (res.ev == mfd_pkg::EV_STORED),
                  slot_q[$past(res.slot)] == $past(res.data))
  `MFD_ASSERT_NXT(a_hold_no_step, !step_i, $stable(in_frame_q) && $stable(cnt_q))

endmodule

/* tb/sv/marked_frame_deframer_tb.sv */
module marked_frame_deframer_tb;
  import mfd_pkg::*;

  localparam int HOLD_CYCLES   = 80;
  localparam int PHASE_ITEMS   = 170;
  localparam int NUM_PHASES    = 5;
  localparam logic [7:0] BYTE_A = 8'h41;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [7:0]             cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;   // [7:0] rx_byte
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [2:0] event_res, [4:3] slot, [52:5] frame_data

  marked_frame_deframer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  typedef struct {
    logic [7:0] b;
    bit         typed;
    event_e     ev;
  } row_t;

  // deframer state as predicted
  logic [7:0]        marker_cur;
  bit                open_frame;
  int                frame_cnt;
  logic [7:0]        frame_bytes [FRAME_BYTES];
  logic [DATA_W-1:0] slot_copy [4];

  res_t expected_events [$];
  int   mismatch_count;
  int   bytes_sent;
  int   results_seen;
  int   stored_seen;
  int   dropped_seen;
  int   started_seen;
  bit   gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 200000);
    $display("Test completed with failures");
    $finish;
  end

  task automatic deframe_byte(input logic [7:0] b, output res_t r);
    int                idx;
    logic [DATA_W-1:0] acc;
    bit                hit;
    slot_e             s;
    r = '0;
    if (!open_frame) begin
      if (b == marker_cur) begin
        open_frame = 1'b1;
        frame_cnt  = 0;
        r.ev       = EV_START;
      end else begin
        r.ev = EV_REJECT;
      end
    end else begin
      idx = (frame_cnt >= FRAME_BYTES) ? FRAME_BYTES - 1 : frame_cnt;
      frame_bytes[idx] = b;
      frame_cnt = idx + 1;
      r.ev = EV_COLLECT;
      if (frame_cnt >= FRAME_BYTES) begin
        acc = '0;
        // older bytes fall off the top when the frame is longer than the field
        for (int i = 0; i < FRAME_BYTES; i++) acc = {acc[DATA_W-9:0], frame_bytes[i]};
        hit = 1'b1;
        s   = SLOT_M;
        case (frame_bytes[0])
          TYPE_M:  s = SLOT_M;
          TYPE_N:  s = SLOT_N;
          TYPE_T:  s = SLOT_T;
          TYPE_L:  s = SLOT_L;
          default: hit = 1'b0;
        endcase
        if (hit && frame_bytes[0] == frame_bytes[FRAME_BYTES-1]) begin
          r.ev = EV_STORED;
          r.slot = s;
          slot_copy[s] = acc;
        end else begin
          r.ev = EV_DROPPED;
        end
        r.data     = acc;
        open_frame = 1'b0;
        frame_cnt  = 0;
      end
    end
  endtask

  // called right after a falling edge, returns right after a falling edge
  task automatic push_byte(input logic [7:0] b, input bit typed, input event_e ev);
    res_t r;
    while (gaps_on && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    deframe_byte(b, r);
    if (typed) begin
      r    = '0;
      r.ev = ev;
    end
    expected_events.push_back(r);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    logic [7:0] first;
    logic [7:0] letters [4];
    letters = '{TYPE_M, TYPE_N, TYPE_T, TYPE_L};
    push_byte(marker_cur, 1'b0, EV_COLLECT);
    first = ($urandom_range(99) < 80) ? letters[$urandom_range(3)] : 8'($urandom_range(255));
    push_byte(first, 1'b0, EV_COLLECT);
    for (int i = 0; i < FRAME_BYTES - 2; i++) begin
      push_byte(($urandom_range(9) == 0) ? marker_cur : 8'($urandom_range(255)),
                1'b0, EV_COLLECT);
    end
    push_byte(($urandom_range(99) < 75) ? first : 8'($urandom_range(255)), 1'b0, EV_COLLECT);
  endtask

  task automatic write_marker(input logic [7:0] v);
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    marker_cur  = v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
             results_seen, field, got, want);
  endtask

  task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
    res_t want;
    if (expected_events.size() == 0) begin
      report_mismatch("unexpected transfer", 64'(word), 64'h0);
      return;
    end
    want = expected_events.pop_front();
    if (word[2:0] != want.ev)         report_mismatch("event", 64'(word[2:0]), 64'(want.ev));
    if (word[4:3] != want.slot)       report_mismatch("slot", 64'(word[4:3]), 64'(want.slot));
    if (word[DATA_W+4:5] != want.data)
      report_mismatch("frame data", 64'(word[DATA_W+4:5]), 64'(want.data));
    if (word[OUT_TDATA_W-1:DATA_W+5] != '0)
      report_mismatch("pad bits", 64'(word[OUT_TDATA_W-1:DATA_W+5]), 64'h0);
    if (want.ev == EV_STORED)  stored_seen++;
    if (want.ev == EV_DROPPED) dropped_seen++;
    if (want.ev == EV_START)   started_seen++;
  endtask

  // result side: random stalls plus one long hold-off while input keeps coming
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (results_seen == 300 && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= !(gaps_on && $urandom_range(99) < 12);
      end
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
        results_seen++;
      end
    end
  end

  initial begin
    row_t       directed_rows [23];
    logic [7:0] phase_marker [NUM_PHASES];
    int         phase_start;
    directed_rows = '{
      '{8'h00, 1'b1, EV_REJECT}, '{8'hff, 1'b1, EV_REJECT},
      // marker inside an open frame is plain data
      '{START_MARKER_RST, 1'b1, EV_START}, '{TYPE_N, 1'b0, EV_COLLECT},
      '{START_MARKER_RST, 1'b0, EV_COLLECT}, '{8'h00, 1'b0, EV_COLLECT},
      '{8'hff, 1'b0, EV_COLLECT}, '{8'h80, 1'b0, EV_COLLECT}, '{TYPE_N, 1'b0, EV_COLLECT},
      // unknown type letter with equal ends
      '{START_MARKER_RST, 1'b1, EV_START}, '{BYTE_A, 1'b0, EV_COLLECT},
      '{8'h01, 1'b0, EV_COLLECT}, '{8'h02, 1'b0, EV_COLLECT}, '{8'h03, 1'b0, EV_COLLECT},
      '{8'h04, 1'b0, EV_COLLECT}, '{BYTE_A, 1'b0, EV_COLLECT},
      // known type, unequal ends
      '{START_MARKER_RST, 1'b1, EV_START}, '{TYPE_L, 1'b0, EV_COLLECT},
      '{8'hff, 1'b0, EV_COLLECT}, '{8'hff, 1'b0, EV_COLLECT}, '{8'hff, 1'b0, EV_COLLECT},
      '{8'hff, 1'b0, EV_COLLECT}, '{TYPE_M, 1'b0, EV_COLLECT}
    };
    phase_marker = '{8'h00, 8'hff, TYPE_M, 8'($urandom_range(255)), START_MARKER_RST};

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    marker_cur    = START_MARKER_RST;
    open_frame    = 1'b0;
    frame_cnt     = 0;
    foreach (slot_copy[i]) slot_copy[i] = '0;
    mismatch_count = 0;
    bytes_sent     = 0;
    results_seen   = 0;
    stored_seen    = 0;
    dropped_seen   = 0;
    started_seen   = 0;
    gaps_on        = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      push_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].ev);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_marker(phase_marker[p]);
      gaps_on     = (p != 2);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 75) begin
          send_frame();
        end else begin
          repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)), 1'b0, EV_COLLECT);
        end
      end
      gaps_on = 1'b1;
    end
    s_axis_tvalid <= 1'b0;

    while (expected_events.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("sent %0d bytes under %0d start-marker settings, checked %0d results",
             bytes_sent, NUM_PHASES + 1, results_seen);
    $display("frames opened %0d, stored %0d, dropped %0d",
             started_seen, stored_seen, dropped_seen);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* marked_frame_deframer.f */
+incdir+rtl
rtl/mfd_pkg.sv
rtl/mfd_parser.sv
rtl/marked_frame_deframer.sv
tb/sv/marked_frame_deframer_tb.sv
